>>> sv/jsu_pkg.sv
package jsu_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] K_DATA   = 2'd0;
  localparam logic [1:0] K_CLOSED = 2'd1;
  localparam logic [1:0] K_ERROR  = 2'd2;

  // Error codes carried in the upper tdata bits of an error result.
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNCLOSED = 3'd1;
  localparam logic [2:0] E_LETTER   = 3'd2;
  localparam logic [2:0] E_HEX      = 3'd3;
  localparam logic [2:0] E_CTRL     = 3'd4;

  // Replacement character for broken surrogates.
  localparam logic [20:0] CP_REPLACE = 21'h00FFFD;

  // Depth of the request queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One request: everything a single input byte produces.
  // An optional code point (a), then an optional second code point or raw
  // byte (b), then an optional closing or error marker (t).
  typedef struct packed {
    logic        a_v;
    logic [20:0] a_cp;
    logic        b_v;
    logic        b_raw;
    logic [15:0] b_val;
    logic        t_v;
    logic [1:0]  t_kind;
    logic [2:0]  t_code;
  } jsu_req_t;

endpackage

>>> sv/jsu_front.sv
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  input  logic            byte_valid,
  output logic            push,
  output jsu_pkg::jsu_req_t req
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    M_NORMAL  = 7'b0000001,
    M_ESC     = 7'b0000010,
    M_HEX1    = 7'b0000100,
    M_HIGH    = 7'b0001000,
    M_HIGH_BS = 7'b0010000,
    M_HEX2    = 7'b0100000,
    M_IDLE    = 7'b1000000
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_SPACE = 8'h20;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] hh_r, hh_nxt;

  // Normal-mode handling of the byte.
  mode_t      n_mode;
  logic       n_close, n_data;
  logic [2:0] n_err;
  // Escape-letter handling of the byte.
  mode_t      e_mode;
  logic       e_hex, e_data;
  logic [7:0] e_byte;
  logic [2:0] e_err;
  // Hex digit decode.
  logic       hd_ok;
  logic [3:0] hd_val;
  logic [15:0] acc_new;
  logic        f_high, f_low;
  logic [20:0] cp_pair;

  jsu_req_t   r;
  logic [2:0] err;

  // Classify the byte as it would be seen in normal mode.
  always_comb begin
    n_mode  = M_NORMAL;
    n_close = 1'b0;
    n_data  = 1'b0;
    n_err   = E_NONE;
    if (text_byte == CH_QUOTE) begin
      n_close = 1'b1;
      n_mode  = M_IDLE;
    end else if (text_byte == CH_BSL) begin
      n_mode = M_ESC;
    end else if (text_byte < CH_SPACE) begin
      n_err = E_CTRL;
    end else begin
      n_data = 1'b1;
    end
  end

  // Classify the byte as an escape letter.
  always_comb begin
    e_mode = M_NORMAL;
    e_hex  = 1'b0;
    e_data = 1'b1;
    e_byte = text_byte;
    e_err  = E_NONE;
    case (text_byte)
      CH_N:     e_byte = 8'h0A;
      CH_T:     e_byte = 8'h09;
      CH_R:     e_byte = 8'h0D;
      CH_B:     e_byte = 8'h08;
      CH_F:     e_byte = 8'h0C;
      CH_QUOTE, CH_BSL, CH_SLASH: e_byte = text_byte;
      CH_U: begin
        e_data = 1'b0;
        e_hex  = 1'b1;
        e_mode = M_HEX1;
      end
      default: begin
        e_data = 1'b0;
        e_err  = E_LETTER;
      end
    endcase
  end

  // Hex digit value and surrogate range checks on the finished value.
  always_comb begin
    hd_ok  = 1'b1;
    hd_val = 4'd0;
    if (text_byte inside {[8'h30:8'h39]}) begin
      hd_val = 4'(text_byte - 8'h30);
    end else if (text_byte inside {[8'h61:8'h66]}) begin
      hd_val = 4'(text_byte - 8'h57);
    end else if (text_byte inside {[8'h41:8'h46]}) begin
      hd_val = 4'(text_byte - 8'h37);
    end else begin
      hd_ok = 1'b0;
    end
    acc_new = {acc_r[11:0], hd_val};
    f_high  = acc_new inside {[16'hD800:16'hDBFF]};
    f_low   = acc_new inside {[16'hDC00:16'hDFFF]};
    cp_pair = 21'h010000 + {1'b0, hh_r[9:0], acc_new[9:0]};
  end

  // Escape state machine and request build.
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hh_nxt   = hh_r;
    r        = '0;
    err      = E_NONE;
    if (byte_valid) begin
      case (mode_r)
        M_ESC: begin
          mode_nxt = e_mode;
          if (e_hex) begin
            cnt_nxt = 2'd0;
            acc_nxt = 16'd0;
          end
          r.b_v   = e_data;
          r.b_val = {8'h00, e_byte};
          err     = e_err;
        end
        M_HEX1, M_HEX2: begin
          if (!hd_ok) begin
            err = E_HEX;
          end else begin
            acc_nxt = acc_new;
            if (cnt_r == 2'd3) begin
              cnt_nxt = 2'd0;
              if (mode_r == M_HEX2 && f_low) begin
                r.a_v    = 1'b1;
                r.a_cp   = cp_pair;
                mode_nxt = M_NORMAL;
              end else begin
                if (mode_r == M_HEX2) begin
                  r.a_v  = 1'b1;
                  r.a_cp = CP_REPLACE;
                end
                if (f_high) begin
                  hh_nxt   = acc_new;
                  mode_nxt = M_HIGH;
                end else begin
                  r.b_v    = 1'b1;
                  r.b_val  = f_low ? CP_REPLACE[15:0] : acc_new;
                  mode_nxt = M_NORMAL;
                end
              end
            end else begin
              cnt_nxt = cnt_r + 2'd1;
            end
          end
        end
        M_HIGH: begin
          if (text_byte == CH_BSL) begin
            mode_nxt = M_HIGH_BS;
          end else begin
            r.a_v    = 1'b1;
            r.a_cp   = CP_REPLACE;
            mode_nxt = n_mode;
            r.t_v    = n_close;
            r.t_kind = K_CLOSED;
            r.b_v    = n_data;
            r.b_raw  = 1'b1;
            r.b_val  = {8'h00, text_byte};
            err      = n_err;
          end
        end
        M_HIGH_BS: begin
          if (text_byte == CH_U) begin
            mode_nxt = M_HEX2;
            cnt_nxt  = 2'd0;
            acc_nxt  = 16'd0;
          end else begin
            r.a_v    = 1'b1;
            r.a_cp   = CP_REPLACE;
            mode_nxt = e_mode;
            r.b_v    = e_data;
            r.b_val  = {8'h00, e_byte};
            err      = e_err;
          end
        end
        default: begin
          mode_nxt = n_mode;
          r.t_v    = n_close;
          r.t_kind = K_CLOSED;
          r.b_v    = n_data;
          r.b_raw  = 1'b1;
          r.b_val  = {8'h00, text_byte};
          err      = n_err;
        end
      endcase
    end

    // End of text while a string is still open.
    if (err == E_NONE && end_of_text && mode_nxt != M_IDLE) begin
      err = (mode_nxt == M_HEX1 || mode_nxt == M_HEX2) ? E_HEX : E_UNCLOSED;
    end

    // An error drops all data of this byte and restarts the scanner.
    if (err != E_NONE) begin
      r        = '0;
      r.t_v    = 1'b1;
      r.t_kind = K_ERROR;
      r.t_code = err;
      mode_nxt = M_NORMAL;
      cnt_nxt  = 2'd0;
      acc_nxt  = 16'd0;
      hh_nxt   = 16'd0;
    end
  end

  assign req  = r;
  assign push = in_accept && (r.a_v || r.b_v || r.t_v);

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      cnt_r  <= 2'd0;
      acc_r  <= 16'd0;
      hh_r   <= 16'd0;
    end else if (in_accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hh_r   <= hh_nxt;
    end
  end

endmodule

>>> sv/jsu_fifo.sv
module jsu_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::jsu_req_t push_req,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output jsu_pkg::jsu_req_t head_req
);
  import jsu_pkg::*;

  jsu_req_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   count_r, count_nxt;

  assign full       = (count_r == QCW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_req   = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

>>> sv/jsu_back.sv
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  jsu_pkg::jsu_req_t head_req,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0]      len;
  } utf8_t;

  // UTF-8 encoding of one code point.
  function automatic utf8_t encode(input logic [20:0] cp);
    utf8_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.len      = 4'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.len      = 4'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.len      = 4'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.len      = 4'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  utf8_t      enc_a, enc_b;
  logic [3:0] len_a, len_b, total, idx4, sub;
  logic [2:0] idx_r, idx_nxt;
  logic       load, item_last;
  logic [7:0] item_byte;
  logic [1:0] item_kind;
  logic [2:0] item_code;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [1:0]  out_kind_r;
  logic [2:0]  out_code_r;
  logic        out_last_r;

  // Pick the current result out of the request at the queue head.
  always_comb begin
    enc_a = encode(head_req.a_cp);
    enc_b = encode({5'd0, head_req.b_val});
    len_a = head_req.a_v ? enc_a.len : 4'd0;
    if (!head_req.b_v) begin
      len_b = 4'd0;
    end else if (head_req.b_raw) begin
      len_b = 4'd1;
      enc_b.bytes[0] = head_req.b_val[7:0];
    end else begin
      len_b = enc_b.len;
    end
    total = len_a + len_b + {3'd0, head_req.t_v};
    idx4  = {1'b0, idx_r};
    sub   = idx4 - len_a;
    item_kind = K_DATA;
    item_code = E_NONE;
    item_byte = 8'h00;
    if (idx4 < len_a) begin
      item_byte = enc_a.bytes[idx_r[1:0]];
    end else if (sub < len_b) begin
      item_byte = enc_b.bytes[sub[1:0]];
    end else begin
      item_kind = head_req.t_kind;
      item_code = head_req.t_code;
    end
    item_last = (idx4 == total - 4'd1);
  end

  assign load    = head_valid && (!out_valid_r || out_tready);
  assign pop     = load && item_last;
  assign idx_nxt = item_last ? 3'd0 : idx_r + 3'd1;

  // Position inside the head request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else if (load) begin
      idx_r <= idx_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= item_byte;
      out_kind_r <= item_kind;
      out_code_r <= item_code;
      out_last_r <= item_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_code_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/json_string_unescape.sv
// JSON string body decoder with UTF-8 output.
// The input stream carries one source byte per request starting after the
// opening quote: in_tdata[7:0] is the byte, in_tuser is set when the byte is
// present (clear for an end-only flush), and in_tlast marks the end of text.
// The output stream carries one result per request: out_tdata[7:0] is the
// decoded byte, out_tdata[10:8] the error code, out_tuser the kind (data,
// string closed, error), and out_tlast the last result caused by one input.
// Each input may produce up to six results; escapes and surrogate pairs
// are resolved in the front scanner and expanded into UTF-8 bytes by the back
// end, with a four-deep request queue in between.
// An accepted input passes the queue and the output register before its first
// result. Plain bytes flow at one per cycle while out_tready is high; an input
// with several results holds the back end until all are sent, and the queue
// absorbs the difference so input is taken every cycle while the queue has room.
// Reset (synchronous, active low) empties the queue, clears the output valid
// and returns the scanner to normal mode inside a string. When the receiver
// stalls, the output register holds its result and the queue fills, after
// which in_tready drops.
module json_string_unescape (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);
  import jsu_pkg::*;

  logic     in_accept, push, full, pop, head_valid;
  jsu_req_t push_req, head_req;

  assign in_tready = !full;
  assign in_accept = in_tvalid && in_tready;

  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .byte_valid  (in_tuser),
    .push        (push),
    .req         (push_req)
  );

  jsu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sim/testbench.sv
module testbench;
  import jsu_pkg::*;

  // Characters that steer the scanner.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Surrogate ranges.
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;

  localparam int RAND_ITEMS = 470;
  localparam int DRAIN_CYCLES = 20;

  // Scanner modes of the predictor.
  typedef enum logic [2:0] {
    SM_TEXT, SM_ESC, SM_HEX1, SM_HIGH, SM_HIGH_BS, SM_HEX2, SM_IDLE
  } scan_t;

  // One source request and one decoded result.
  typedef struct packed {
    logic [7:0] ch;
    logic       bval;
    logic       eot;
    logic       hold;
  } src_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  json_string_unescape dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  src_t text_q[$];
  res_t decoded_q[$];
  src_t cur_src;
  res_t got_exp;
  bit   hold_next = 1'b0;
  bit   skip_in;
  int   n_in = 0;
  int   n_queued = 0;
  int   n_res = 0;
  int   n_close = 0;
  int   n_errres = 0;
  int   n_fail = 0;

  // Decoder state as the predictor sees it.
  scan_t       sm = SM_TEXT;
  logic [1:0]  ndig = 2'd0;
  logic [15:0] acc = 16'd0;
  logic [15:0] hi_sur = 16'd0;
  res_t        step_q[$];
  logic [2:0]  step_err;

  task automatic report_mismatch(string msg);
    n_fail++;
    if (n_fail <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic bit quiet_phase();
    return n_in >= 200 && n_in < 300;
  endfunction

  function automatic int nib_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  // Decoded byte of a one-letter escape, or -1 when the letter is not one.
  function automatic int esc_value(logic [7:0] c);
    case (c)
      8'h6E: return 8'h0A;
      8'h74: return 8'h09;
      8'h72: return 8'h0D;
      8'h62: return 8'h08;
      8'h66: return 8'h0C;
      CH_QUOTE, CH_BSLASH, 8'h2F: return int'(c);
      default: return -1;
    endcase
  endfunction

  function automatic void put(logic [7:0] b, logic [1:0] k, logic [2:0] e);
    res_t r;
    r.data = b;
    r.kind = k;
    r.code = e;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  // UTF-8 encoding of one code point.
  function automatic void put_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      put(cp[7:0], K_DATA, E_NONE);
    end else if (cp < 21'h800) begin
      put({3'b110, cp[10:6]}, K_DATA, E_NONE);
      put({2'b10, cp[5:0]}, K_DATA, E_NONE);
    end else if (cp < 21'h10000) begin
      put({4'b1110, cp[15:12]}, K_DATA, E_NONE);
      put({2'b10, cp[11:6]}, K_DATA, E_NONE);
      put({2'b10, cp[5:0]}, K_DATA, E_NONE);
    end else begin
      put({5'b11110, cp[20:18]}, K_DATA, E_NONE);
      put({2'b10, cp[17:12]}, K_DATA, E_NONE);
      put({2'b10, cp[11:6]}, K_DATA, E_NONE);
      put({2'b10, cp[5:0]}, K_DATA, E_NONE);
    end
  endfunction

  function automatic void text_char(logic [7:0] c);
    if (c == CH_QUOTE) begin
      put(8'd0, K_CLOSED, E_NONE);
      sm = SM_IDLE;
    end else if (c == CH_BSLASH) begin
      sm = SM_ESC;
    end else if (c < CH_SPACE) begin
      step_err = E_CTRL;
    end else begin
      put(c, K_DATA, E_NONE);
      sm = SM_TEXT;
    end
  endfunction

  function automatic void esc_char(logic [7:0] c);
    int v;
    v = esc_value(c);
    if (c == CH_U) begin
      sm = SM_HEX1;
      ndig = 2'd0;
      acc = 16'd0;
    end else if (v < 0) begin
      step_err = E_LETTER;
    end else begin
      put(v[7:0], K_DATA, E_NONE);
      sm = SM_TEXT;
    end
  endfunction

  // Returns 1 once the fourth digit of an escape has been taken.
  function automatic bit take_digit(logic [7:0] c);
    int d;
    d = nib_of(c);
    if (d < 0) begin
      step_err = E_HEX;
      return 1'b0;
    end
    acc = {acc[11:0], d[3:0]};
    if (ndig == 2'd3) begin
      ndig = 2'd0;
      return 1'b1;
    end
    ndig = ndig + 2'd1;
    return 1'b0;
  endfunction

  // A complete first escape: a high half waits for its partner.
  function automatic void first_done(logic [15:0] v);
    if (v >= HIGH_FIRST && v <= HIGH_LAST) begin
      hi_sur = v;
      sm = SM_HIGH;
    end else begin
      put_cp((v >= LOW_FIRST && v <= LOW_LAST) ? CP_REPLACE : {5'd0, v});
      sm = SM_TEXT;
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    case (sm)
      SM_ESC: esc_char(c);
      SM_HEX1: if (take_digit(c)) first_done(acc);
      SM_HIGH: begin
        if (c == CH_BSLASH) begin
          sm = SM_HIGH_BS;
        end else begin
          put_cp(CP_REPLACE);
          sm = SM_TEXT;
          text_char(c);
        end
      end
      SM_HIGH_BS: begin
        if (c == CH_U) begin
          sm = SM_HEX2;
          ndig = 2'd0;
          acc = 16'd0;
        end else begin
          put_cp(CP_REPLACE);
          esc_char(c);
        end
      end
      SM_HEX2: begin
        if (take_digit(c)) begin
          if (acc >= LOW_FIRST && acc <= LOW_LAST) begin
            put_cp(21'h10000 + {1'b0, hi_sur[9:0], acc[9:0]});
            sm = SM_TEXT;
          end else begin
            put_cp(CP_REPLACE);
            first_done(acc);
          end
        end
      end
      default: text_char(c);
    endcase
  endfunction

  // Expected results of one accepted request, appended to the decoded queue.
  function automatic void decode_request(src_t s);
    step_q = {};
    step_err = E_NONE;
    if (s.bval) scan_byte(s.ch);
    if (step_err == E_NONE && s.eot && sm != SM_IDLE)
      step_err = (sm == SM_HEX1 || sm == SM_HEX2) ? E_HEX : E_UNCLOSED;
    if (step_err != E_NONE) begin
      step_q = {};
      put(8'd0, K_ERROR, step_err);
      sm = SM_TEXT;
      ndig = 2'd0;
      acc = 16'd0;
      hi_sur = 16'd0;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  // Stimulus builders.
  task automatic add_item(logic [7:0] c, logic bval, logic eot);
    src_t s;
    s.ch = c;
    s.bval = bval;
    s.eot = eot;
    s.hold = hold_next;
    hold_next = 1'b0;
    text_q.push_back(s);
    n_queued++;
  endtask

  task automatic add_ch(logic [7:0] c);
    add_item(c, 1'b1, 1'b0);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_ch(s[i]);
  endtask

  function automatic logic [7:0] hex_ch(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] plain_ch();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h41;
    return c;
  endfunction

  function automatic logic [7:0] simple_letter();
    case ($urandom_range(0, 7))
      0: return 8'h6E;
      1: return 8'h74;
      2: return 8'h72;
      3: return 8'h62;
      4: return 8'h66;
      5: return CH_QUOTE;
      6: return CH_BSLASH;
      default: return 8'h2F;
    endcase
  endfunction

  // Backslash, u and the leading nd hex digits of v.
  task automatic add_u(logic [15:0] v, int nd = 4);
    add_ch(CH_BSLASH);
    add_ch(CH_U);
    for (int i = 0; i < nd; i++) add_ch(hex_ch(v[15 - 4 * i -: 4]));
  endtask

  function automatic logic [15:0] high_val();
    return HIGH_FIRST + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] low_val();
    return LOW_FIRST + 16'($urandom_range(0, 16'h3FF));
  endfunction

  task automatic add_good_token();
    case ($urandom_range(0, 9))
      0, 1, 2: add_ch(plain_ch());
      3: add_ch(8'($urandom_range(128, 255)));
      4: begin
        add_ch(CH_BSLASH);
        add_ch(simple_letter());
      end
      5: add_u(16'($urandom_range(0, 16'hFFFF)));
      6: add_u(16'($urandom_range(0, 16'h7FF)));
      7: begin
        add_u(high_val());
        add_u(low_val());
      end
      8: add_u(low_val());
      default: begin
        // A high half followed by something other than a low half.
        add_u(high_val());
        case ($urandom_range(0, 3))
          0: add_ch(plain_ch());
          1: begin
            add_ch(CH_BSLASH);
            add_ch(simple_letter());
          end
          2: add_u($urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                        : 16'($urandom_range(16'hE000, 16'hFFFF)));
          default: add_u(high_val());
        endcase
      end
    endcase
  endtask

  task automatic add_broken();
    logic [7:0] c;
    int k;
    for (int i = $urandom_range(0, 3); i > 0; i--) add_good_token();
    k = $urandom_range(0, 3);
    case ($urandom_range(0, 6))
      0: begin
        add_ch(CH_BSLASH);
        do c = 8'($urandom_range(0, 255)); while (esc_value(c) >= 0 || c == CH_U);
        add_ch(c);
      end
      1: begin
        add_u(16'($urandom_range(0, 16'hFFFF)), k);
        do c = 8'($urandom_range(0, 255)); while (nib_of(c) >= 0);
        add_ch(c);
      end
      2: add_ch(8'($urandom_range(0, 31)));
      3: add_item($urandom_range(0, 1) ? plain_ch() : 8'($urandom_range(128, 255)),
                  1'b1, 1'b1);
      4: begin
        // End of text inside the hex digits.
        add_u(16'($urandom_range(0, 16'hFFFF)), k);
        if (k > 0 && $urandom_range(0, 1)) text_q[text_q.size() - 1].eot = 1'b1;
        else add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      5: begin
        add_u(high_val());
        case ($urandom_range(0, 2))
          0: begin
            add_ch(CH_BSLASH);
            do c = 8'($urandom_range(0, 255)); while (esc_value(c) >= 0 || c == CH_U);
            add_ch(c);
          end
          1: begin
            add_u(low_val(), k);
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          end
          default: add_ch(8'($urandom_range(0, 31)));
        endcase
      end
      default: begin
        if ($urandom_range(0, 1)) add_ch(CH_BSLASH);
        else add_u(high_val());
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic add_good_string();
    for (int i = $urandom_range(1, 8); i > 0; i--) add_good_token();
    add_item(CH_QUOTE, 1'b1, $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) == 0)
      add_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic add_noise();
    for (int i = $urandom_range(1, 6); i > 0; i--)
      add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) != 0),
               1'($urandom_range(0, 9) == 0));
  endtask

  // Driver: presents queued source requests, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_request(cur_src);
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        skip_in = !quiet_phase() && ($urandom_range(0, 99) < 38);
        if (text_q.size() != 0 && !skip_in &&
            !(text_q[0].hold && decoded_q.size() != 0)) begin
          cur_src = text_q.pop_front();
          in_tdata <= cur_src.ch;
          in_tuser <= cur_src.bval;
          in_tlast <= cur_src.eot;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h tuser=%0d tlast=%0b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          got_exp = decoded_q.pop_front();
          n_res++;
          if (got_exp.kind == K_CLOSED) n_close++;
          if (got_exp.kind == K_ERROR) n_errres++;
          if (out_tdata[7:0] !== got_exp.data || out_tdata[10:8] !== got_exp.code ||
              out_tdata[15:11] !== 5'd0 || out_tuser !== got_exp.kind ||
              out_tlast !== got_exp.last)
            report_mismatch($sformatf(
              "result %0d: byte %h code %0d kind %0d last %0b, wanted %h %0d %0d %0b",
              n_res, out_tdata[7:0], out_tdata[10:8], out_tuser, out_tlast,
              got_exp.data, got_exp.code, got_exp.kind, got_exp.last));
        end
      end
      out_tready <= quiet_phase() || ($urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    // Directed part: field extremes and the corner cases of the scanner.
    add_ch(8'h00);
    add_ch(8'hFF);
    add_ch(CH_SPACE);
    add_text("\\q");
    add_text("\\u12G");
    add_text("\\uD800x");
    add_item(8'hA5, 1'b0, 1'b0);
    add_ch(CH_QUOTE);
    add_item(8'h5A, 1'b0, 1'b1);
    add_item(8'h61, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1);
    add_text("\\u0");
    add_item(8'hFF, 1'b0, 1'b1);

    // Random part: mostly well-formed strings, some broken ones and noise.
    for (int seg = 0; n_queued < RAND_ITEMS; seg++) begin
      int pick;
      pick = $urandom_range(0, 99);
      hold_next = (seg % 40 == 0);
      if (pick < 65) add_good_string();
      else if (pick < 85) add_broken();
      else add_noise();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (n_in != n_queued || decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d source requests; checked %0d results with %0d closes, %0d errors.",
             n_in, n_res, n_close, n_errres);
    $display("Mix of well-formed strings, surrogates, broken escapes and random noise.");
    if (n_fail == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
